// ----- rtl/pvop_pkg.sv -----
// Package for project_vector_onto_plane: word types and sizing constants.
// No dependencies.
`default_nettype none
package pvop_pkg;
  localparam int CompWidth = 32;
  localparam int FracBits  = 30;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] plane_a_x;
    logic signed [31:0] plane_a_y;
    logic signed [31:0] plane_a_z;
    logic signed [31:0] plane_b_x;
    logic signed [31:0] plane_b_y;
    logic signed [31:0] plane_b_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] unit_x;
    logic signed [31:0] unit_y;
    logic signed [31:0] unit_z;
    logic               degenerate;
  } out_word_t;
endpackage
`default_nettype wire

// ----- rtl/project_vector_onto_plane.sv -----
// Top level of project_vector_onto_plane: plane normal, double cross
// product and normalisation, plus its limb multiplier. Depends on pvop_pkg.
// ---------------------------------------------------------------------
// Usage: an input word (target s, plane vectors a, b) enters on the in_
// valid/ready channel; one output word leaves on the out_ channel.
// The direction is r = (n x s) x n with n = a x b, normalised to unit
// length in Q2.30, rounded to nearest with ties away from zero.
// If a, b, s, n or n x s is zero the degenerate bit is set and the unit
// components are zero.
// Throughput: one word per cycle when the receiver does not stall. The
// pipeline has NSTG = 15 + FRAC_BITS + 2 register stages (47 at
// defaults). The wide products use three-stage multipliers of 33 x 33
// limbs; each stage of the normalisation decides one quotient bit.
// Reset clears every stage's valid bit; data registers are not reset.
// When the receiver stalls, the whole pipeline holds (global enable),
// so nothing is lost or repeated; in_ready follows out_ready or an
// empty output stage.
// ---------------------------------------------------------------------
`default_nettype none
module project_vector_onto_plane #(
  parameter int COMPONENT_WIDTH      = pvop_pkg::CompWidth,
  parameter int RESULT_FRACTION_BITS = pvop_pkg::FracBits
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  pvop_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output pvop_pkg::out_word_t  out_data
);
  import pvop_pkg::*;

  localparam int W  = COMPONENT_WIDTH;
  localparam int F  = RESULT_FRACTION_BITS;
  localparam int NW = 2 * W + 2;    // n = a x b
  localparam int MW = NW + W + 2;   // m = n x s
  localparam int RW = MW + NW + 2;  // r = m x n
  localparam int SW = 2 * RW + 2;   // sum of squares
  localparam int TW = SW + 2 * F + 4; // scaled square compare width
  localparam int QW = F + 2;
  localparam int NB = F + 1;        // quotient bits, one per stage

  // Pipeline advances whenever the output can move.
  logic adv;
  assign adv      = out_ready | ~out_valid;
  assign in_ready = adv;

  // --- stage 1: load; zero check of s, a and b ---
  logic signed [W-1:0] s_r [3];
  logic signed [W-1:0] a_r [3];
  logic signed [W-1:0] b_r [3];
  logic                z1_r;
  logic                z1_nxt;
  assign z1_nxt = (in_data.target_x[W-1:0] == '0 && in_data.target_y[W-1:0] == '0 &&
                   in_data.target_z[W-1:0] == '0) ||
                  (in_data.plane_a_x[W-1:0] == '0 && in_data.plane_a_y[W-1:0] == '0 &&
                   in_data.plane_a_z[W-1:0] == '0) ||
                  (in_data.plane_b_x[W-1:0] == '0 && in_data.plane_b_y[W-1:0] == '0 &&
                   in_data.plane_b_z[W-1:0] == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r[0] <= in_data.target_x[W-1:0];
      s_r[1] <= in_data.target_y[W-1:0];
      s_r[2] <= in_data.target_z[W-1:0];
      a_r[0] <= in_data.plane_a_x[W-1:0];
      a_r[1] <= in_data.plane_a_y[W-1:0];
      a_r[2] <= in_data.plane_a_z[W-1:0];
      b_r[0] <= in_data.plane_b_x[W-1:0];
      b_r[1] <= in_data.plane_b_y[W-1:0];
      b_r[2] <= in_data.plane_b_z[W-1:0];
      z1_r   <= z1_nxt;
    end
  end

  // --- stage 2: products for n ---
  logic signed [2*W-1:0] np_r [3];
  logic signed [2*W-1:0] nq_r [3];
  logic signed [W-1:0]   s2_r [3];
  logic                  z2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        np_r[i] <= a_r[(i+1)%3] * b_r[(i+2)%3];
        nq_r[i] <= a_r[(i+2)%3] * b_r[(i+1)%3];
        s2_r[i] <= s_r[i];
      end
      z2_r <= z1_r;
    end
  end

  // --- stage 3: n ---
  logic signed [NW-1:0] n3_r [3];
  logic signed [W-1:0]  s3_r [3];
  logic                 z3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        n3_r[i] <= NW'(np_r[i]) - NW'(nq_r[i]);
        s3_r[i] <= s2_r[i];
      end
      z3_r <= z2_r;
    end
  end

  // --- stages 4 to 6: products for m = n x s; n rides alongside ---
  logic signed [NW-1:0] n4_r [3];
  logic signed [NW-1:0] n5_r [3];
  logic signed [NW-1:0] n6_r [3];
  logic                 z4_r, z5_r, z6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      n4_r <= n3_r;
      n5_r <= n4_r;
      n6_r <= n5_r;
      z4_r <= z3_r || (n3_r[0] == '0 && n3_r[1] == '0 && n3_r[2] == '0);
      z5_r <= z4_r;
      z6_r <= z5_r;
    end
  end

  // --- stage 7: m ---
  logic signed [MW-1:0] m7_r [3];
  logic signed [NW-1:0] n7_r [3];
  logic                 z7_r;
  for (genvar g = 0; g < 3; g++) begin : g_m
    logic signed [NW+W-1:0] pa, pb;
    pvop_mul #(.AW(NW), .BW(W)) u_pa (
      .clk(clk), .en(adv), .a(n3_r[(g+1)%3]), .b(s3_r[(g+2)%3]), .p(pa)
    );
    pvop_mul #(.AW(NW), .BW(W)) u_pb (
      .clk(clk), .en(adv), .a(n3_r[(g+2)%3]), .b(s3_r[(g+1)%3]), .p(pb)
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        m7_r[g] <= MW'(pa) - MW'(pb);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      n7_r <= n6_r;
      z7_r <= z6_r;
    end
  end

  // --- stages 8 to 10: products for r = m x n ---
  logic z8_r, z9_r, z10_r, z11_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      z8_r  <= z7_r || (m7_r[0] == '0 && m7_r[1] == '0 && m7_r[2] == '0);
      z9_r  <= z8_r;
      z10_r <= z9_r;
      z11_r <= z10_r;
    end
  end

  // --- stage 11: r ---
  logic signed [RW-1:0] r11_r [3];
  for (genvar g = 0; g < 3; g++) begin : g_r
    logic signed [MW+NW-1:0] pa, pb;
    pvop_mul #(.AW(MW), .BW(NW)) u_pa (
      .clk(clk), .en(adv), .a(m7_r[(g+1)%3]), .b(n7_r[(g+2)%3]), .p(pa)
    );
    pvop_mul #(.AW(MW), .BW(NW)) u_pb (
      .clk(clk), .en(adv), .a(m7_r[(g+2)%3]), .b(n7_r[(g+1)%3]), .p(pb)
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        r11_r[g] <= RW'(pa) - RW'(pb);
      end
    end
  end

  // --- stages 12 to 14: squares; sign bits ride alongside ---
  logic [2*RW-1:0] sq [3];
  logic            neg12_r [3];
  logic            neg13_r [3];
  logic            neg14_r [3];
  logic            z12_r, z13_r, z14_r;
  for (genvar g = 0; g < 3; g++) begin : g_sq
    logic signed [2*RW-1:0] pq;
    pvop_mul #(.AW(RW), .BW(RW)) u_sq (
      .clk(clk), .en(adv), .a(r11_r[g]), .b(r11_r[g]), .p(pq)
    );
    assign sq[g] = pq;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        neg12_r[i] <= r11_r[i][RW-1];
        neg13_r[i] <= neg12_r[i];
        neg14_r[i] <= neg13_r[i];
      end
      z12_r <= z11_r;
      z13_r <= z12_r;
      z14_r <= z13_r;
    end
  end

  // --- stage 15: sum, and t = x^2 << 2F per lane ---
  logic [TW-1:0] sum15_r;
  logic [TW-1:0] t15_r [3];
  logic          neg15_r [3];
  logic          z15_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sum15_r <= TW'(sq[0]) + TW'(sq[1]) + TW'(sq[2]);
      for (int i = 0; i < 3; i++) begin
        t15_r[i]   <= TW'(sq[i]) << (2 * F);
        neg15_r[i] <= neg14_r[i];
      end
      z15_r <= z14_r;
    end
  end

  // --- quotient stages: one bit of q per stage, MSB first ---
  // Keeps q and sum*q^2 so each trial needs only shifts and adds:
  // (q+2^k)^2*S = q^2*S + 2^(k+1)*q*S + 2^(2k)*S, with q*S kept too.
  logic [TW-1:0] sum_q   [NB+1];
  logic [TW-1:0] t_q     [NB+1][3];
  logic [TW-1:0] p_q     [NB+1][3];  // S*q^2
  logic [TW-1:0] qs_q    [NB+1][3];  // S*q
  logic [QW-1:0] q_q     [NB+1][3];
  logic          neg_q   [NB+1][3];
  logic          z_q     [NB+1];

  always_comb begin
    sum_q[0] = sum15_r;
    z_q[0]   = z15_r;
    for (int i = 0; i < 3; i++) begin
      t_q[0][i]   = t15_r[i];
      p_q[0][i]   = '0;
      qs_q[0][i]  = '0;
      q_q[0][i]   = '0;
      neg_q[0][i] = neg15_r[i];
    end
  end

  for (genvar g = 0; g < NB; g++) begin : g_qbit
    localparam int K = F - g;
    logic [TW-1:0] sum_r, t_r [3], p_r [3], qs_r [3];
    logic [QW-1:0] q_r [3];
    logic          neg_r [3], z_r;
    logic [TW-1:0] p_try [3];
    logic [QW-1:0] q_try [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        q_try[i] = q_q[g][i] | (QW'(1) << K);
        p_try[i] = p_q[g][i] + (qs_q[g][i] << (K + 1)) + (sum_q[g] << (2 * K));
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sum_r <= sum_q[g];
        z_r   <= z_q[g];
        for (int i = 0; i < 3; i++) begin
          t_r[i]   <= t_q[g][i];
          neg_r[i] <= neg_q[g][i];
          // a trial bit is kept only if q stays within 2^F and S*q^2 does not exceed t
          if (q_try[i] <= (QW'(1) << F) && p_try[i] <= t_q[g][i]) begin
            q_r[i]  <= q_try[i];
            p_r[i]  <= p_try[i];
            qs_r[i] <= qs_q[g][i] + (sum_q[g] << K);
          end else begin
            q_r[i]  <= q_q[g][i];
            p_r[i]  <= p_q[g][i];
            qs_r[i] <= qs_q[g][i];
          end
        end
      end
    end
    always_comb begin
      sum_q[g+1] = sum_r;
      z_q[g+1]   = z_r;
      for (int i = 0; i < 3; i++) begin
        t_q[g+1][i]   = t_r[i];
        p_q[g+1][i]   = p_r[i];
        qs_q[g+1][i]  = qs_r[i];
        q_q[g+1][i]   = q_r[i];
        neg_q[g+1][i] = neg_r[i];
      end
    end
  end

  // --- final stage: rounding, (2q+1)^2*S <= 4t, i.e. 4qqS+4qS+S <= 4t ---
  logic [QW-1:0] qr [3];
  logic [31:0]   uo [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qr[i] = q_q[NB][i];
      if ((p_q[NB][i] << 2) + (qs_q[NB][i] << 2) + sum_q[NB] <= (t_q[NB][i] << 2))
        qr[i] = q_q[NB][i] + QW'(1);
      uo[i] = neg_q[NB][i] ? 32'(-{{(64-QW){1'b0}}, qr[i]}) : 32'({{(64-QW){1'b0}}, qr[i]});
    end
  end

  // valid bits: stages 1..15, NB quotient stages, output
  localparam int NSTG = 15 + NB + 1;
  logic [NSTG-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.degenerate <= z_q[NB];
      out_data.unit_x     <= z_q[NB] ? '0 : uo[0];
      out_data.unit_y     <= z_q[NB] ? '0 : uo[1];
      out_data.unit_z     <= z_q[NB] ? '0 : uo[2];
    end
  end
endmodule

// Three-stage signed multiplier from 33 x 33 limb products:
// limb products, then row sums, then the final sum.
module pvop_mul #(
  parameter int AW = pvop_pkg::CompWidth,
  parameter int BW = pvop_pkg::CompWidth
) (
  input  wire                      clk,
  input  wire                      en,
  input  wire  signed [AW-1:0]     a,
  input  wire  signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);
  localparam int LW = 32;
  localparam int LA = (AW + LW - 1) / LW;
  localparam int LB = (BW + LW - 1) / LW;
  localparam int PW = AW + BW;

  logic signed [LA*LW-1:0] a_x;
  logic signed [LB*LW-1:0] b_x;
  logic signed [LW:0]      a_l [LA];
  logic signed [LW:0]      b_l [LB];
  logic signed [2*LW+1:0]  pp_r [LA][LB];
  logic signed [PW-1:0]    row_nxt [LA];
  logic signed [PW-1:0]    row_r [LA];
  logic signed [PW-1:0]    prod_nxt;
  logic signed [PW-1:0]    prod_r;

  assign a_x = (LA*LW)'(a);
  assign b_x = (LB*LW)'(b);

  // top limb carries the sign, lower limbs are unsigned
  always_comb begin
    for (int i = 0; i < LA; i++) begin
      a_l[i] = {(i == LA - 1) ? a_x[i*LW+LW-1] : 1'b0, a_x[i*LW +: LW]};
    end
    for (int j = 0; j < LB; j++) begin
      b_l[j] = {(j == LB - 1) ? b_x[j*LW+LW-1] : 1'b0, b_x[j*LW +: LW]};
    end
  end

  always_comb begin
    for (int i = 0; i < LA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < LB; j++) begin
        row_nxt[i] = row_nxt[i] + (PW'(pp_r[i][j]) << (LW * j));
      end
    end
    prod_nxt = '0;
    for (int i = 0; i < LA; i++) begin
      prod_nxt = prod_nxt + (row_r[i] << (LW * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LA; i++) begin
        for (int j = 0; j < LB; j++) begin
          pp_r[i][j] <= a_l[i] * b_l[j];
        end
      end
      row_r  <= row_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign p = prod_r;
endmodule
`default_nettype wire
